FILE: design/orq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the ranking function for the ordered ready queue.
// No dependencies.
package orq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int PID_W       = 15;
	localparam int PRIO_W      = 8;
	localparam int TIME_W      = 24;
	localparam int OCC_W       = 6;
	localparam int STATUS_W    = 2;

	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] rtime;
	} entry_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic   ins;
		logic   ext;
		entry_t entry;
	} cell_cmd_t;

	// true when a must stand before b
	function automatic logic ranks_above(entry_t a, entry_t b);
		if (a.prio != b.prio) begin
			return a.prio > b.prio;
		end
		if (a.rtime != b.rtime) begin
			return a.rtime < b.rtime;
		end
		return a.pid < b.pid;
	endfunction

endpackage

FILE: design/orq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted shift row: holds an entry and moves it left or right.
// Depends on orq_pkg.
module orq_cell (
	input  logic               clk,
	input  orq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               left_take,
	input  orq_pkg::entry_t    left_entry,
	input  orq_pkg::entry_t    right_entry,
	output logic               take,
	output orq_pkg::entry_t    entry_q
);
	import orq_pkg::*;

	// slot is at or past the insert point; monotone along the row
	assign take = !occupied || ranks_above(cmd.entry, entry_q);

	always_ff @(posedge clk) begin
		if (cmd.ins && take) begin
			entry_q <= left_take ? left_entry : cmd.entry;
		end else if (cmd.ext) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: design/ordered_ready_queue.sv
`timescale 1ns / 1ps
// Top level of the ordered ready queue: cell row, entry count, result register.
// Depends on orq_pkg and orq_cell.

// Sorted ready queue of QUEUE_DEPTH process entries, front entry first. Each item is
// an insert or an extract and gives exactly one result, registered and shown from the
// cycle after the item is taken. Every cell compares itself with the new entry and
// shifts in the same edge; req_ready is high whenever the result register is empty or
// being drained, giving one item per cycle when rsp_ready stays high. A full insert
// returns status full, an extract from an empty queue returns status empty; entry
// fields of the result are zero except on a good extract.
module ordered_ready_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          operation,
	input  logic [orq_pkg::PID_W-1:0]     proc_id,
	input  logic [orq_pkg::PRIO_W-1:0]    priority_req,
	input  logic [orq_pkg::TIME_W-1:0]    time_left,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [orq_pkg::STATUS_W-1:0]  status,
	output logic [orq_pkg::PID_W-1:0]     out_proc_id,
	output logic [orq_pkg::PRIO_W-1:0]    out_priority,
	output logic [orq_pkg::TIME_W-1:0]    out_remaining,
	output logic [orq_pkg::OCC_W-1:0]     occupancy
);
	import orq_pkg::*;

	count_t    count_q;
	count_t    count_d;
	logic      rsp_valid_q;
	status_t   status_q;
	entry_t    out_entry_q;
	logic [OCC_W-1:0] occ_q;
	logic      accept;
	logic      is_extract;
	logic      full;
	logic      empty;
	cell_cmd_t cmd;
	status_t   status_d;

	entry_t row_entry [QUEUE_DEPTH];
	logic   row_take  [QUEUE_DEPTH];

	assign req_ready  = !rsp_valid_q || rsp_ready;
	assign accept     = req_valid && req_ready;
	assign is_extract = (operation == OP_EXTRACT);
	assign full       = (count_q == count_t'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);

	always_comb begin
		cmd.ins         = accept && !is_extract && !full;
		cmd.ext         = accept && is_extract && !empty;
		cmd.entry.pid   = proc_id;
		cmd.entry.prio  = priority_req;
		cmd.entry.rtime = time_left;
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + count_t'(1);
		end else if (cmd.ext) begin
			count_d = count_q - count_t'(1);
		end
	end

	always_comb begin
		priority if (is_extract && empty) begin
			status_d = STATUS_EMPTY;
		end else if (!is_extract && full) begin
			status_d = STATUS_FULL;
		end else begin
			status_d = STATUS_DONE;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic   occ_here;
			logic   l_take;
			entry_t l_entry;
			entry_t r_entry;

			assign occ_here = (count_q > count_t'(gi));

			if (gi == 0) begin : g_first
				assign l_take  = 1'b0;
				assign l_entry = '0;
			end else begin : g_mid
				assign l_take  = row_take[gi-1];
				assign l_entry = row_entry[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign r_entry = '0;
			end else begin : g_inner
				assign r_entry = row_entry[gi+1];
			end

			orq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occ_here),
				.left_take   (l_take),
				.left_entry  (l_entry),
				.right_entry (r_entry),
				.take        (row_take[gi]),
				.entry_q     (row_entry[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			out_entry_q <= cmd.ext ? row_entry[0] : '0;
			occ_q       <= OCC_W'(count_d);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign out_proc_id   = out_entry_q.pid;
	assign out_priority  = out_entry_q.prio;
	assign out_remaining = out_entry_q.rtime;
	assign occupancy     = occ_q;

	// entry count stays within the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	// a full result leaves the queue full
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == STATUS_FULL && $rose(rsp_valid_q)
		|-> count_q == count_t'(QUEUE_DEPTH))
		else $error("full status but queue not full");

	// an empty result leaves the queue empty
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == STATUS_EMPTY && $rose(rsp_valid_q) |-> count_q == '0)
		else $error("empty status but queue holds entries");

	// front two cells stay in order
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= count_t'(2) |-> !ranks_above(row_entry[1], row_entry[0]))
		else $error("front cells out of order");

endmodule
